>>> hw/rtl/apqm_pkg.sv
`default_nettype none

package apqm_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int FILL_W        = 4;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] key;
      logic [63:0]        name_low;
      logic [15:0]        name_high;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_key;
      logic [63:0]        out_name_low;
      logic [15:0]        out_name_high;
      logic [FILL_W-1:0]  fill;
   } rsp_type;

   // one stored entry, as kept in the slot memory
   typedef struct packed {
      logic signed [31:0] key;
      logic [63:0]        name_low;
      logic [15:0]        name_high;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

>>> hw/rtl/array_priority_queue_max.sv
// Channel   Ports                      Handshake
// request   start, busy, req_item      taken when start is high and busy is low
// response  rsp_valid, rsp_item        one cycle per item, strobe rsp_valid
//
// Enqueue: result on the next cycle; a new item may follow at once.
// Dequeue of n held entries with the winner at slot b: busy for n reads
// through the memory's single read port to find the largest key, then
// n-1-b read/write pairs to close the gap; result in the cycle after.
// Full and empty cases answer on the next cycle. Reset empties the queue; the slot
// memory itself is not cleared. Results cannot be held off by the receiver.
`default_nettype none

module array_priority_queue_max #(
   parameter int DEPTH = apqm_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire apqm_pkg::req_type req_item,
   output logic                   rsp_valid,
   output apqm_pkg::rsp_type      rsp_item
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int FillW = apqm_pkg::FILL_W;
   localparam int EntW  = apqm_pkg::ENTRY_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   apqm_pkg::entry_type best_ff, best_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   apqm_pkg::rsp_type   rsp_ff, rsp_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   apqm_pkg::entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [EntW-1:0]     ram_rd_bits;
   apqm_pkg::entry_type ram_rd_data;

   logic [CW-1:0]       last_idx;
   logic                take_new;
   apqm_pkg::entry_type sel_entry;
   logic [AW-1:0]       sel_idx;
   apqm_pkg::entry_type new_entry;

   apqm_ram #(
      .WIDTH (EntW),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = apqm_pkg::entry_type'(ram_rd_bits);
   assign last_idx    = count_ff - CW'(1);

   assign new_entry.key       = req_item.key;
   assign new_entry.name_low  = req_item.name_low;
   assign new_entry.name_high = req_item.name_high;

   // strict compare keeps the oldest entry among equal keys
   assign take_new  = (idx_ff == '0) || ($signed(ram_rd_data.key) > $signed(best_ff.key));
   assign sel_entry = take_new ? ram_rd_data : best_ff;
   assign sel_idx   = take_new ? idx_ff : best_idx_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = new_entry;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in.out_key       = '0;
               rsp_in.out_name_low  = '0;
               rsp_in.out_name_high = '0;
               if (req_item.operation == apqm_pkg::OP_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CW'(DEPTH)) begin
                     rsp_in.status = apqm_pkg::STATUS_FULL;
                     rsp_in.fill   = FillW'(count_ff);
                  end else begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = count_ff[AW-1:0];
                     count_in      = count_ff + CW'(1);
                     rsp_in.status = apqm_pkg::STATUS_DONE;
                     rsp_in.fill   = FillW'(count_ff + CW'(1));
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = apqm_pkg::STATUS_EMPTY;
                     rsp_in.fill   = '0;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            // read data for slot idx_ff arrives this cycle
            best_in     = sel_entry;
            best_idx_in = sel_idx;
            if (CW'(idx_ff) != last_idx) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(CW'(idx_ff) + CW'(1));
               idx_in      = AW'(CW'(idx_ff) + CW'(1));
            end else if (CW'(sel_idx) != last_idx) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(CW'(sel_idx) + CW'(1));
               idx_in      = sel_idx;
               state_in    = ST_SHIFT;
            end else begin
               count_in             = last_idx;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = apqm_pkg::STATUS_DONE;
               rsp_in.out_key       = sel_entry.key;
               rsp_in.out_name_low  = sel_entry.name_low;
               rsp_in.out_name_high = sel_entry.name_high;
               rsp_in.fill          = FillW'(last_idx);
               state_in             = ST_IDLE;
            end
         end

         ST_SHIFT: begin
            // slot idx_ff+1 arrives; move it down one
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            if (CW'(idx_ff) + CW'(1) != last_idx) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(CW'(idx_ff) + CW'(2));
               idx_in      = AW'(CW'(idx_ff) + CW'(1));
            end else begin
               count_in             = last_idx;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = apqm_pkg::STATUS_DONE;
               rsp_in.out_key       = best_ff.key;
               rsp_in.out_name_low  = best_ff.name_low;
               rsp_in.out_name_high = best_ff.name_high;
               rsp_in.fill          = FillW'(last_idx);
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/apqm_ram.sv
`default_nettype none

module apqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
